/* rtl/core/gossip_membership_failure_detector_top_defines.svh */
// Assertion macros for the failure detector RTL; gmfd_back is the file that includes them.
// Depends on nothing; files that check their own logic include it.
`ifndef GOSSIP_MEMBERSHIP_FAILURE_DETECTOR_TOP_DEFINES_SVH
`define GOSSIP_MEMBERSHIP_FAILURE_DETECTOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define GMFD_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GMFD_NEVER(name, clk, rst_n, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define GMFD_ASSERT(name, clk, rst_n, prop, msg)
`define GMFD_NEVER(name, clk, rst_n, expr, msg)
`endif
`endif

/* rtl/core/gmfd_pkg.sv */
// Types, codes and constants of the gossip membership failure detector.
// Used by every module of the block but gmfd_ram; depends on nothing.
package gmfd_pkg;

    localparam int MEMBERS_DEF = 32;
    localparam int SLOT_W      = 5;
    localparam int BEAT_W      = 32;
    localparam int INC_W       = 16;
    localparam int TMO_W       = 8;
    localparam int OUTQ_DEPTH  = 4;
    localparam int CMDQ_DEPTH  = 2;

    localparam logic [2:0] CMD_GOSSIP = 3'd0;
    localparam logic [2:0] CMD_CLOCK  = 3'd1;
    localparam logic [2:0] CMD_BEAT   = 3'd2;
    localparam logic [2:0] CMD_SWEEP  = 3'd3;
    localparam logic [2:0] CMD_ADD    = 3'd4;

    localparam logic [2:0] EV_DONE      = 3'd0;
    localparam logic [2:0] EV_ADDED     = 3'd1;
    localparam logic [2:0] EV_PRESENT   = 3'd2;
    localparam logic [2:0] EV_LEARNED   = 3'd3;
    localparam logic [2:0] EV_SUSPECTED = 3'd4;
    localparam logic [2:0] EV_FAILED    = 3'd5;
    localparam logic [2:0] EV_CLEARED   = 3'd6;
    localparam logic [2:0] EV_REFUTED   = 3'd7;

    localparam logic [1:0] CFG_SELF_SLOT   = 2'd0;
    localparam logic [1:0] CFG_SUSP_MODE   = 2'd1;
    localparam logic [1:0] CFG_FAIL_TMO    = 2'd2;
    localparam logic [1:0] CFG_SUSPECT_TMO = 2'd3;

    localparam logic [TMO_W-1:0] FAIL_TMO_RESET    = 8'd8;
    localparam logic [TMO_W-1:0] SUSPECT_TMO_RESET = 8'd2;

    typedef struct packed {
        logic [2:0]        cmd;
        logic [SLOT_W-1:0] slot;
        logic [BEAT_W-1:0] beat_count;
        logic [INC_W-1:0]  incarnation_in;
        logic              suspect_in;
    } in_t;

    typedef struct packed {
        logic [2:0]        event_res;
        logic [SLOT_W-1:0] member;
        logic [INC_W-1:0]  own_incarnation;
        logic              last;
    } res_t;

    // Operation after classification
    typedef enum logic [2:0] {
        OP_NOP,
        OP_GOSSIP,
        OP_CLOCK,
        OP_BEAT,
        OP_SWEEP,
        OP_ADD
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [SLOT_W-1:0] slot;
        logic [BEAT_W-1:0] beat;
        logic [INC_W-1:0]  inc;
        logic              sus;
        logic [SLOT_W-1:0] member;
    } cmd_word_t;

    typedef struct packed {
        logic [BEAT_W-1:0] beat;
        logic [BEAT_W-1:0] seen;
        logic [INC_W-1:0]  inc;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

/* rtl/core/gmfd_ram.sv */
// Generic single write, single read RAM with registered read data.
// Depends on nothing.
module gmfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/core/gmfd_front.sv */
// Front end: accepts input words, classifies them and queues them for the back end.
// Depends on gmfd_pkg.
module gmfd_front #(
    parameter int MEMBERS = gmfd_pkg::MEMBERS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  gmfd_pkg::in_t               item,
    input  logic [gmfd_pkg::SLOT_W-1:0] self_slot,
    input  logic                        suspicion_mode,
    output logic                        cmd_avail,
    input  logic                        cmd_pop,
    output gmfd_pkg::cmd_word_t         cmd
);

    localparam int QAW = $clog2(gmfd_pkg::CMDQ_DEPTH);

    gmfd_pkg::cmd_word_t q_reg [gmfd_pkg::CMDQ_DEPTH];
    logic [QAW-1:0]      wptr_reg, wptr_next;
    logic [QAW-1:0]      rptr_reg, rptr_next;
    logic [QAW:0]        count_reg, count_next;
    gmfd_pkg::cmd_word_t cls;
    logic                in_range;
    logic                accept;

    assign in_range = 32'(item.slot) < 32'(MEMBERS);

    always_comb
    begin
        cls.op     = gmfd_pkg::OP_NOP;
        cls.slot   = item.slot;
        cls.beat   = item.beat_count;
        cls.inc    = item.incarnation_in;
        cls.sus    = item.suspect_in;
        cls.member = self_slot;
        unique case (item.cmd)
            gmfd_pkg::CMD_GOSSIP:
            begin
                cls.member = item.slot;
                // out of table, or self in plain mode: nothing to do
                if (in_range && !(item.slot == self_slot && !suspicion_mode))
                begin
                    cls.op = gmfd_pkg::OP_GOSSIP;
                end
            end
            gmfd_pkg::CMD_CLOCK:
            begin
                cls.op = gmfd_pkg::OP_CLOCK;
            end
            gmfd_pkg::CMD_BEAT:
            begin
                if (32'(self_slot) < 32'(MEMBERS))
                begin
                    cls.op = gmfd_pkg::OP_BEAT;
                end
            end
            gmfd_pkg::CMD_SWEEP:
            begin
                cls.op = gmfd_pkg::OP_SWEEP;
            end
            gmfd_pkg::CMD_ADD:
            begin
                cls.member = item.slot;
                if (in_range)
                begin
                    cls.op = gmfd_pkg::OP_ADD;
                end
            end
            default:
            begin
                cls.op = gmfd_pkg::OP_NOP;
            end
        endcase
    end

    assign full      = count_reg == (QAW+1)'(gmfd_pkg::CMDQ_DEPTH);
    assign cmd_avail = count_reg != '0;
    assign cmd       = q_reg[rptr_reg];
    assign accept    = push && !full;

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (accept)
        begin
            wptr_next = wptr_reg + 1'b1;
        end
        if (cmd_pop && cmd_avail)
        begin
            rptr_next = rptr_reg + 1'b1;
        end
        if (accept && !(cmd_pop && cmd_avail))
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!accept && cmd_pop && cmd_avail)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_reg[wptr_reg] <= cls;
        end
    end

endmodule

/* rtl/core/gmfd_outq.sv */
// Result queue between the back end and the result ports.
// Depends on gmfd_pkg.
module gmfd_outq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr,
    input  gmfd_pkg::res_t wdata,
    output logic           room,
    output logic           empty,
    input  logic           pop,
    output gmfd_pkg::res_t result
);

    localparam int AW = $clog2(gmfd_pkg::OUTQ_DEPTH);

    gmfd_pkg::res_t q_reg [gmfd_pkg::OUTQ_DEPTH];
    logic [AW-1:0]  wptr_reg, wptr_next;
    logic [AW-1:0]  rptr_reg, rptr_next;
    logic [AW:0]    count_reg, count_next;
    logic           do_wr;
    logic           do_rd;

    assign room   = count_reg != (AW+1)'(gmfd_pkg::OUTQ_DEPTH);
    assign empty  = count_reg == '0;
    assign result = q_reg[rptr_reg];
    assign do_wr  = wr && room;
    assign do_rd  = pop && !empty;

    always_comb
    begin
        wptr_next  = do_wr ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next  = do_rd ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_wr && do_rd)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            q_reg[wptr_reg] <= wdata;
        end
    end

endmodule

/* rtl/core/gmfd_back.sv */
// Back end: member table, local clock, and the sequencer that carries out commands.
// Depends on gmfd_pkg, gmfd_ram and the assertion macros header.
`include "gossip_membership_failure_detector_top_defines.svh"
module gmfd_back #(
    parameter int MEMBERS = gmfd_pkg::MEMBERS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_avail,
    output logic                        cmd_pop,
    input  gmfd_pkg::cmd_word_t         cmd,
    input  logic [gmfd_pkg::SLOT_W-1:0] self_slot,
    input  logic                        suspicion_mode,
    input  logic [gmfd_pkg::TMO_W-1:0]  fail_timeout,
    input  logic [gmfd_pkg::TMO_W-1:0]  suspect_timeout,
    output logic                        out_push,
    output gmfd_pkg::res_t              out_res,
    input  logic                        out_room
);

    localparam int IDX_W = $clog2(MEMBERS);
    localparam int CW    = (IDX_W > gmfd_pkg::SLOT_W) ? IDX_W : gmfd_pkg::SLOT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OWN,
        S_ENTRY,
        S_SWEEP,
        S_SW_END,
        S_EMIT
    } state_t;

    state_t                       state_reg, state_next;
    gmfd_pkg::cmd_word_t          cur_reg, cur_next;
    logic [gmfd_pkg::BEAT_W-1:0]  clock_reg, clock_next;
    logic [gmfd_pkg::INC_W-1:0]   own_reg, own_next;
    logic [MEMBERS-1:0]           present_reg, present_next;
    logic [MEMBERS-1:0]           expelled_reg, expelled_next;
    logic [MEMBERS-1:0]           susp_reg, susp_next;
    logic [MEMBERS-1:0]           valid_reg, valid_next;
    logic [IDX_W-1:0]             idx_reg, idx_next;
    logic                         rdv_reg, rdv_next;
    logic                         pend_reg, pend_next;
    logic [2:0]                   pend_ev_reg, pend_ev_next;
    logic [gmfd_pkg::SLOT_W-1:0]  pend_mem_reg, pend_mem_next;
    logic [2:0]                   res_ev_reg, res_ev_next;
    logic [gmfd_pkg::SLOT_W-1:0]  res_mem_reg, res_mem_next;

    logic                         ram_we;
    logic [IDX_W-1:0]             ram_waddr;
    gmfd_pkg::entry_t             ram_wdata;
    logic                         ram_re;
    logic [IDX_W-1:0]             ram_raddr;
    logic [gmfd_pkg::ENTRY_W-1:0] ram_rdata;
    gmfd_pkg::entry_t             entry;

    logic [CW-1:0]                self_cw;
    logic [CW-1:0]                slot_cw;
    logic [CW-1:0]                idx_cw;
    logic [IDX_W-1:0]             self_idx;
    logic [IDX_W-1:0]             slot_idx;
    logic                         self_in;
    logic                         is_self;
    logic [gmfd_pkg::BEAT_W-1:0]  age;

    assign self_cw  = CW'(self_slot);
    assign slot_cw  = CW'(cur_reg.slot);
    assign idx_cw   = CW'(idx_reg);
    assign self_idx = self_cw[IDX_W-1:0];
    assign slot_idx = slot_cw[IDX_W-1:0];
    assign self_in  = 32'(self_slot) < 32'(MEMBERS);
    assign is_self  = cur_reg.slot == self_slot;
    // entries never written since reset or failure read as zero
    assign entry    = rdv_reg ? gmfd_pkg::entry_t'(ram_rdata) : '0;
    assign age      = clock_reg - entry.seen;

    gmfd_ram #(
        .WIDTH (gmfd_pkg::ENTRY_W),
        .DEPTH (MEMBERS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        logic [gmfd_pkg::INC_W-1:0]  g_inc;
        logic [gmfd_pkg::BEAT_W-1:0] g_beat;
        logic [gmfd_pkg::BEAT_W-1:0] g_seen;
        logic                        g_susp;
        logic [2:0]                  g_ev;
        logic                        sw_ev;
        logic                        sw_fail;
        logic [2:0]                  sw_code;

        state_next    = state_reg;
        cur_next      = cur_reg;
        clock_next    = clock_reg;
        own_next      = own_reg;
        present_next  = present_reg;
        expelled_next = expelled_reg;
        susp_next     = susp_reg;
        valid_next    = valid_reg;
        idx_next      = idx_reg;
        rdv_next      = rdv_reg;
        pend_next     = pend_reg;
        pend_ev_next  = pend_ev_reg;
        pend_mem_next = pend_mem_reg;
        res_ev_next   = res_ev_reg;
        res_mem_next  = res_mem_reg;
        cmd_pop       = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = slot_idx;
        ram_wdata     = '0;
        ram_re        = 1'b0;
        ram_raddr     = self_idx;
        out_push      = 1'b0;
        out_res       = '0;
        g_inc         = entry.inc;
        g_beat        = entry.beat;
        g_seen        = entry.seen;
        g_susp        = susp_reg[slot_idx];
        g_ev          = gmfd_pkg::EV_DONE;
        sw_ev         = 1'b0;
        sw_fail       = 1'b0;
        sw_code       = gmfd_pkg::EV_DONE;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_avail)
                begin
                    cmd_pop    = 1'b1;
                    cur_next   = cmd;
                    ram_re     = 1'b1;
                    ram_raddr  = self_idx;
                    state_next = S_OWN;
                end
            end
            S_OWN:
            begin
                own_next     = self_in ? entry.inc : '0;
                res_ev_next  = gmfd_pkg::EV_DONE;
                res_mem_next = cur_reg.member;
                unique case (cur_reg.op)
                    gmfd_pkg::OP_CLOCK:
                    begin
                        clock_next = clock_reg + 1'b1;
                        state_next = S_EMIT;
                    end
                    gmfd_pkg::OP_BEAT:
                    begin
                        // own entry is the word just read
                        ram_we               = 1'b1;
                        ram_waddr            = self_idx;
                        ram_wdata            = entry;
                        ram_wdata.beat       = entry.beat + 1'b1;
                        valid_next[self_idx] = 1'b1;
                        state_next           = S_EMIT;
                    end
                    gmfd_pkg::OP_GOSSIP, gmfd_pkg::OP_ADD:
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = slot_idx;
                        state_next = S_ENTRY;
                    end
                    gmfd_pkg::OP_SWEEP:
                    begin
                        idx_next   = '0;
                        ram_re     = 1'b1;
                        ram_raddr  = '0;
                        pend_next  = 1'b0;
                        state_next = S_SWEEP;
                    end
                    default:
                    begin
                        state_next = S_EMIT;
                    end
                endcase
            end
            S_ENTRY:
            begin
                res_mem_next = cur_reg.member;
                state_next   = S_EMIT;
                if (cur_reg.op == gmfd_pkg::OP_ADD)
                begin
                    if (present_reg[slot_idx])
                    begin
                        res_ev_next = gmfd_pkg::EV_PRESENT;
                    end
                    else
                    begin
                        present_next[slot_idx] = 1'b1;
                        susp_next[slot_idx]    = 1'b0;
                        valid_next[slot_idx]   = 1'b1;
                        ram_we                 = 1'b1;
                        ram_wdata.seen         = clock_reg;
                        res_ev_next            = gmfd_pkg::EV_ADDED;
                        if (is_self)
                        begin
                            own_next = '0;
                        end
                    end
                end
                else
                begin
                    if (is_self && cur_reg.sus && cur_reg.inc == g_inc)
                    begin
                        g_inc = g_inc + 1'b1;
                        g_ev  = gmfd_pkg::EV_REFUTED;
                    end
                    if (present_reg[slot_idx] || is_self)
                    begin
                        if (cur_reg.beat > entry.beat)
                        begin
                            g_beat = cur_reg.beat;
                            g_seen = clock_reg;
                        end
                        if (suspicion_mode)
                        begin
                            if (cur_reg.sus)
                            begin
                                if (g_inc < cur_reg.inc)
                                begin
                                    g_inc  = cur_reg.inc;
                                    g_susp = 1'b1;
                                    g_ev   = gmfd_pkg::EV_SUSPECTED;
                                end
                            end
                            else if (g_susp && cur_reg.inc > g_inc)
                            begin
                                g_susp = 1'b0;
                                g_inc  = cur_reg.inc;
                                g_seen = clock_reg;
                                g_ev   = gmfd_pkg::EV_CLEARED;
                            end
                        end
                        ram_we               = 1'b1;
                        ram_wdata.beat       = g_beat;
                        ram_wdata.seen       = g_seen;
                        ram_wdata.inc        = g_inc;
                        valid_next[slot_idx] = 1'b1;
                        susp_next[slot_idx]  = g_susp;
                        if (is_self)
                        begin
                            own_next = g_inc;
                        end
                    end
                    else if (!expelled_reg[slot_idx])
                    begin
                        // learn a new member
                        present_next[slot_idx] = 1'b1;
                        susp_next[slot_idx]    = cur_reg.sus;
                        valid_next[slot_idx]   = 1'b1;
                        ram_we                 = 1'b1;
                        ram_wdata.beat         = cur_reg.beat;
                        ram_wdata.seen         = clock_reg;
                        ram_wdata.inc          = cur_reg.inc;
                        g_ev                   = gmfd_pkg::EV_LEARNED;
                    end
                    res_ev_next = g_ev;
                end
            end
            S_SWEEP:
            begin
                if (!(self_in && idx_reg == self_idx) && present_reg[idx_reg])
                begin
                    if (suspicion_mode)
                    begin
                        if (age > 32'(suspect_timeout) && !susp_reg[idx_reg])
                        begin
                            sw_ev   = 1'b1;
                            sw_code = gmfd_pkg::EV_SUSPECTED;
                        end
                        else if (age > 32'(fail_timeout) && susp_reg[idx_reg])
                        begin
                            sw_ev   = 1'b1;
                            sw_fail = 1'b1;
                            sw_code = gmfd_pkg::EV_FAILED;
                        end
                    end
                    else if (age > 32'(fail_timeout))
                    begin
                        sw_ev   = 1'b1;
                        sw_fail = 1'b1;
                        sw_code = gmfd_pkg::EV_FAILED;
                    end
                end
                // hold the slot while an earlier event cannot leave
                if (!(sw_ev && pend_reg && !out_room))
                begin
                    if (sw_ev)
                    begin
                        if (pend_reg)
                        begin
                            out_push                = 1'b1;
                            out_res.event_res       = pend_ev_reg;
                            out_res.member          = pend_mem_reg;
                            out_res.own_incarnation = own_reg;
                            out_res.last            = 1'b0;
                        end
                        pend_next     = 1'b1;
                        pend_ev_next  = sw_code;
                        pend_mem_next = idx_cw[gmfd_pkg::SLOT_W-1:0];
                        if (sw_fail)
                        begin
                            present_next[idx_reg]  = 1'b0;
                            expelled_next[idx_reg] = 1'b1;
                            susp_next[idx_reg]     = 1'b0;
                            valid_next[idx_reg]    = 1'b0;
                        end
                        else
                        begin
                            susp_next[idx_reg] = 1'b1;
                        end
                    end
                    if (idx_reg == IDX_W'(MEMBERS - 1))
                    begin
                        state_next = S_SW_END;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        ram_re     = 1'b1;
                        ram_raddr  = idx_reg + 1'b1;
                        state_next = S_SWEEP;
                    end
                end
            end
            S_SW_END:
            begin
                if (out_room)
                begin
                    out_push                = 1'b1;
                    out_res.event_res       = pend_reg ? pend_ev_reg : gmfd_pkg::EV_DONE;
                    out_res.member          = pend_reg ? pend_mem_reg : self_slot;
                    out_res.own_incarnation = own_reg;
                    out_res.last            = 1'b1;
                    state_next              = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (out_room)
                begin
                    out_push                = 1'b1;
                    out_res.event_res       = res_ev_reg;
                    out_res.member          = res_mem_reg;
                    out_res.own_incarnation = own_reg;
                    out_res.last            = 1'b1;
                    state_next              = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (ram_re)
        begin
            rdv_next = valid_reg[ram_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            clock_reg    <= '0;
            present_reg  <= '0;
            expelled_reg <= '0;
            susp_reg     <= '0;
            valid_reg    <= '0;
            pend_reg     <= 1'b0;
            rdv_reg      <= 1'b0;
            idx_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clock_reg    <= clock_next;
            present_reg  <= present_next;
            expelled_reg <= expelled_next;
            susp_reg     <= susp_next;
            valid_reg    <= valid_next;
            pend_reg     <= pend_next;
            rdv_reg      <= rdv_next;
            idx_reg      <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        own_reg      <= own_next;
        pend_ev_reg  <= pend_ev_next;
        pend_mem_reg <= pend_mem_next;
        res_ev_reg   <= res_ev_next;
        res_mem_reg  <= res_mem_next;
    end

    `GMFD_NEVER(a_no_rw_collide, clk, rst_n,
        ram_we && ram_re && ram_waddr == ram_raddr,
        "table read and write hit the same slot")
    `GMFD_ASSERT(a_push_has_room, clk, rst_n,
        out_push |-> out_room,
        "result written into a full queue")
    `GMFD_ASSERT(a_last_ends_item, clk, rst_n,
        (out_push && out_res.last) |=> state_reg == S_IDLE,
        "sequencer busy after the final word")

endmodule

/* rtl/core/gossip_membership_failure_detector_top.sv */
// Top level of the gossip membership failure detector: configuration registers and wiring.
// Depends on gmfd_pkg, gmfd_front, gmfd_back and gmfd_outq.
//
// Each input word enters a two-word command queue and the back end carries it out against a
// member table held in one RAM with a single read port: a clock tick, heartbeat tick or no-op
// passes through states OWN and EMIT, a gossip entry or local add through OWN, ENTRY and EMIT,
// and a failure sweep through OWN, SWEEP (one slot per cycle while no event waits on a full
// result queue) and SW_END. Results leave through a four-word queue; when it fills the back end
// waits, the command queue fills, full rises and input waits until results are popped.
// Reset takes effect at once: per-slot valid bits stand in for clearing the table.
module gossip_membership_failure_detector_top #(
    parameter int MEMBERS = gmfd_pkg::MEMBERS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  gmfd_pkg::in_t              item,
    output logic                       empty,
    input  logic                       pop,
    output gmfd_pkg::res_t             result,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [1:0]                 cfg_index,
    input  logic [gmfd_pkg::TMO_W-1:0] cfg_data
);

    logic [gmfd_pkg::SLOT_W-1:0] self_slot_reg;
    logic                        susp_mode_reg;
    logic [gmfd_pkg::TMO_W-1:0]  fail_tmo_reg;
    logic [gmfd_pkg::TMO_W-1:0]  suspect_tmo_reg;

    logic                cmd_avail;
    logic                cmd_pop;
    gmfd_pkg::cmd_word_t cmd;
    logic                out_push;
    gmfd_pkg::res_t      out_res;
    logic                out_room;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            self_slot_reg   <= '0;
            susp_mode_reg   <= 1'b0;
            fail_tmo_reg    <= gmfd_pkg::FAIL_TMO_RESET;
            suspect_tmo_reg <= gmfd_pkg::SUSPECT_TMO_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                gmfd_pkg::CFG_SELF_SLOT:   self_slot_reg   <= cfg_data[gmfd_pkg::SLOT_W-1:0];
                gmfd_pkg::CFG_SUSP_MODE:   susp_mode_reg   <= cfg_data[0];
                gmfd_pkg::CFG_FAIL_TMO:    fail_tmo_reg    <= cfg_data;
                gmfd_pkg::CFG_SUSPECT_TMO: suspect_tmo_reg <= cfg_data;
                default:                   self_slot_reg   <= self_slot_reg;
            endcase
        end
    end

    gmfd_front #(
        .MEMBERS (MEMBERS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .item           (item),
        .self_slot      (self_slot_reg),
        .suspicion_mode (susp_mode_reg),
        .cmd_avail      (cmd_avail),
        .cmd_pop        (cmd_pop),
        .cmd            (cmd)
    );

    gmfd_back #(
        .MEMBERS (MEMBERS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_avail       (cmd_avail),
        .cmd_pop         (cmd_pop),
        .cmd             (cmd),
        .self_slot       (self_slot_reg),
        .suspicion_mode  (susp_mode_reg),
        .fail_timeout    (fail_tmo_reg),
        .suspect_timeout (suspect_tmo_reg),
        .out_push        (out_push),
        .out_res         (out_res),
        .out_room        (out_room)
    );

    gmfd_outq u_outq (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (out_push),
        .wdata  (out_res),
        .room   (out_room),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

endmodule

/* tb/tb_top.sv */
// Self-checking bench for gossip_membership_failure_detector_top: directed and random words
// checked against a predictor of the member table. Depends on gmfd_pkg and the RTL top.
module tb_top;

    class membership_predictor;
        logic [gmfd_pkg::SLOT_W-1:0] self_slot = '0;
        logic                        susp_mode = 1'b0;
        logic [gmfd_pkg::TMO_W-1:0]  fail_tmo = gmfd_pkg::FAIL_TMO_RESET;
        logic [gmfd_pkg::TMO_W-1:0]  suspect_tmo = gmfd_pkg::SUSPECT_TMO_RESET;
        bit                          present [gmfd_pkg::MEMBERS_DEF];
        bit                          expelled [gmfd_pkg::MEMBERS_DEF];
        bit                          suspected [gmfd_pkg::MEMBERS_DEF];
        logic [gmfd_pkg::BEAT_W-1:0] beats [gmfd_pkg::MEMBERS_DEF];
        logic [gmfd_pkg::BEAT_W-1:0] seen_at [gmfd_pkg::MEMBERS_DEF];
        logic [gmfd_pkg::INC_W-1:0]  incs [gmfd_pkg::MEMBERS_DEF];
        logic [gmfd_pkg::BEAT_W-1:0] local_clock = '0;
        gmfd_pkg::res_t              expected_events [$];
        int                          errors = 0;
        int                          words_in = 0;
        int                          words_out = 0;
        int                          ev_seen [8];

        function void clear_table();
            for (int i = 0; i < gmfd_pkg::MEMBERS_DEF; i++)
            begin
                present[i] = 0;
                expelled[i] = 0;
                suspected[i] = 0;
                beats[i] = '0;
                seen_at[i] = '0;
                incs[i] = '0;
            end
        endfunction

        function void write_reg(logic [1:0] idx, logic [gmfd_pkg::TMO_W-1:0] data);
            case (idx)
                gmfd_pkg::CFG_SELF_SLOT:   self_slot = data[gmfd_pkg::SLOT_W-1:0];
                gmfd_pkg::CFG_SUSP_MODE:   susp_mode = data[0];
                gmfd_pkg::CFG_FAIL_TMO:    fail_tmo = data;
                gmfd_pkg::CFG_SUSPECT_TMO: suspect_tmo = data;
                default:                   susp_mode = susp_mode;
            endcase
        endfunction

        function logic [2:0] merge_gossip(gmfd_pkg::in_t x);
            logic [2:0] ev;
            int         s;
            bit         is_self;
            ev = gmfd_pkg::EV_DONE;
            s = int'(x.slot);
            is_self = (x.slot == self_slot);
            if (is_self && !susp_mode)
                return gmfd_pkg::EV_DONE;
            if (is_self && x.suspect_in && x.incarnation_in == incs[s])
            begin
                incs[s] = incs[s] + 1'b1;
                ev = gmfd_pkg::EV_REFUTED;
            end
            if (present[s] || is_self)
            begin
                if (x.beat_count > beats[s])
                begin
                    beats[s] = x.beat_count;
                    seen_at[s] = local_clock;
                end
                if (susp_mode)
                begin
                    if (x.suspect_in)
                    begin
                        if (incs[s] < x.incarnation_in)
                        begin
                            incs[s] = x.incarnation_in;
                            suspected[s] = 1;
                            ev = gmfd_pkg::EV_SUSPECTED;
                        end
                    end
                    else if (suspected[s] && x.incarnation_in > incs[s])
                    begin
                        suspected[s] = 0;
                        incs[s] = x.incarnation_in;
                        seen_at[s] = local_clock;
                        ev = gmfd_pkg::EV_CLEARED;
                    end
                end
                return ev;
            end
            if (expelled[s])
                return gmfd_pkg::EV_DONE;
            present[s] = 1;
            beats[s] = x.beat_count;
            incs[s] = x.incarnation_in;
            suspected[s] = x.suspect_in;
            seen_at[s] = local_clock;
            return gmfd_pkg::EV_LEARNED;
        endfunction

        function void expel(int i);
            present[i] = 0;
            expelled[i] = 1;
            suspected[i] = 0;
            beats[i] = '0;
            seen_at[i] = '0;
            incs[i] = '0;
        endfunction

        // Work out every result word that one accepted input word causes.
        function void note_input(gmfd_pkg::in_t x);
            gmfd_pkg::res_t              evs [$];
            gmfd_pkg::res_t              r;
            logic [gmfd_pkg::BEAT_W-1:0] age;
            int                          s;
            s = int'(x.slot);
            r = '0;
            words_in++;
            case (x.cmd)
                gmfd_pkg::CMD_GOSSIP:
                begin
                    r.event_res = merge_gossip(x);
                    r.member = x.slot;
                    evs = {evs, r};
                end
                gmfd_pkg::CMD_CLOCK:
                begin
                    local_clock = local_clock + 1'b1;
                    r.member = self_slot;
                    evs = {evs, r};
                end
                gmfd_pkg::CMD_BEAT:
                begin
                    beats[self_slot] = beats[self_slot] + 1'b1;
                    r.member = self_slot;
                    evs = {evs, r};
                end
                gmfd_pkg::CMD_SWEEP:
                begin
                    for (int i = 0; i < gmfd_pkg::MEMBERS_DEF; i++)
                    begin
                        if (i == int'(self_slot) || !present[i])
                            continue;
                        age = local_clock - seen_at[i];
                        r.member = gmfd_pkg::SLOT_W'(i);
                        if (susp_mode)
                        begin
                            if (age > 32'(suspect_tmo) && !suspected[i])
                            begin
                                suspected[i] = 1;
                                r.event_res = gmfd_pkg::EV_SUSPECTED;
                                evs = {evs, r};
                            end
                            else if (age > 32'(fail_tmo) && suspected[i])
                            begin
                                expel(i);
                                r.event_res = gmfd_pkg::EV_FAILED;
                                evs = {evs, r};
                            end
                        end
                        else if (age > 32'(fail_tmo))
                        begin
                            expel(i);
                            r.event_res = gmfd_pkg::EV_FAILED;
                            evs = {evs, r};
                        end
                    end
                    if (evs.size() == 0)
                    begin
                        r.event_res = gmfd_pkg::EV_DONE;
                        r.member = self_slot;
                        evs = {evs, r};
                    end
                end
                gmfd_pkg::CMD_ADD:
                begin
                    r.member = x.slot;
                    if (present[s])
                    begin
                        r.event_res = gmfd_pkg::EV_PRESENT;
                    end
                    else
                    begin
                        present[s] = 1;
                        beats[s] = '0;
                        incs[s] = '0;
                        suspected[s] = 0;
                        seen_at[s] = local_clock;
                        r.event_res = gmfd_pkg::EV_ADDED;
                    end
                    evs = {evs, r};
                end
                default:
                begin
                    r.member = self_slot;
                    evs = {evs, r};
                end
            endcase
            foreach (evs[k])
            begin
                evs[k].own_incarnation = incs[self_slot];
                evs[k].last = (k == evs.size() - 1);
                expected_events = {expected_events, evs[k]};
            end
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("ERROR t=%0t result %0d: %s got %0h expected %0h",
                     $time, words_out, what, got, want);
        endtask

        task check_result(gmfd_pkg::res_t got);
            gmfd_pkg::res_t want;
            words_out++;
            ev_seen[got.event_res]++;
            if (expected_events.size() == 0)
            begin
                report("unexpected word, event", 32'(got.event_res), 32'd0);
                return;
            end
            want = expected_events.pop_front();
            if (got.event_res !== want.event_res)
                report("event_res", 32'(got.event_res), 32'(want.event_res));
            if (got.member !== want.member)
                report("member", 32'(got.member), 32'(want.member));
            if (got.own_incarnation !== want.own_incarnation)
                report("own_incarnation", 32'(got.own_incarnation),
                       32'(want.own_incarnation));
            if (got.last !== want.last)
                report("last", 32'(got.last), 32'(want.last));
        endtask
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       push = 1'b0;
    logic                       full;
    gmfd_pkg::in_t              item = '0;
    logic                       empty;
    logic                       pop = 1'b0;
    gmfd_pkg::res_t             result;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [1:0]                 cfg_index = '0;
    logic [gmfd_pkg::TMO_W-1:0] cfg_data = '0;

    membership_predictor table_model = new;
    int                  tx_idle_pct = 37;
    int                  rx_idle_pct = 47;
    bit                  hold_req = 0;
    int                  quiet_cycles = 0;

    localparam int QUIET_LIMIT = 5000;
    localparam int SETTLE = 60;

    gossip_membership_failure_detector_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .empty    (empty),
        .pop      (pop),
        .result   (result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Result side: check each popped word, stall at random or for a long hold-off.
    initial
    begin
        int hold;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
                table_model.check_result(result);
            if (hold_req)
            begin
                hold = 300;
                hold_req = 0;
            end
            if (hold > 0)
            begin
                hold--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("gossip_membership_failure_detector_top: mismatch");
            $finish;
        end
    end

    task automatic send_word(gmfd_pkg::in_t x);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            push <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < tx_idle_pct);
        end
        item <= x;
        push <= 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        table_model.note_input(x);
    endtask

    task automatic send(logic [2:0] cmd, int s, logic [31:0] beat, logic [15:0] inc, bit sus);
        gmfd_pkg::in_t x;
        x.cmd = cmd;
        x.slot = gmfd_pkg::SLOT_W'(s);
        x.beat_count = beat;
        x.incarnation_in = inc;
        x.suspect_in = sus;
        send_word(x);
    endtask

    task automatic drain();
        push <= 1'b0;
        while (table_model.expected_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [gmfd_pkg::TMO_W-1:0] data);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        table_model.write_reg(idx, data);
        @(posedge clk);
    endtask

    task automatic configure(int self_s, bit mode, int fail_t, int susp_t);
        drain();
        write_reg(gmfd_pkg::CFG_SELF_SLOT, gmfd_pkg::TMO_W'(self_s));
        write_reg(gmfd_pkg::CFG_SUSP_MODE, gmfd_pkg::TMO_W'(mode));
        write_reg(gmfd_pkg::CFG_FAIL_TMO, gmfd_pkg::TMO_W'(fail_t));
        write_reg(gmfd_pkg::CFG_SUSPECT_TMO, gmfd_pkg::TMO_W'(susp_t));
    endtask

    function automatic gmfd_pkg::in_t random_word();
        gmfd_pkg::in_t x;
        int            pick;
        int            s;
        x.beat_count = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(20);
        x.incarnation_in = gmfd_pkg::INC_W'(($urandom_range(4) == 0) ? $urandom()
                                                                     : $urandom_range(6));
        x.suspect_in = 1'($urandom_range(1));
        s = int'(($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(7));
        x.slot = gmfd_pkg::SLOT_W'(s);
        pick = int'($urandom_range(99));
        if (pick < 38)
        begin
            x.cmd = gmfd_pkg::CMD_GOSSIP;
            // hit the refute, suspicion and clearing paths with well-formed incarnations
            if ($urandom_range(4) == 0)
            begin
                x.slot = table_model.self_slot;
                x.suspect_in = 1'b1;
                x.incarnation_in = table_model.incs[table_model.self_slot];
            end
            else if ($urandom_range(2) == 0)
                x.incarnation_in = gmfd_pkg::INC_W'(table_model.incs[s] + $urandom_range(1));
        end
        else if (pick < 60)
            x.cmd = gmfd_pkg::CMD_CLOCK;
        else if (pick < 67)
            x.cmd = gmfd_pkg::CMD_BEAT;
        else if (pick < 78)
            x.cmd = gmfd_pkg::CMD_SWEEP;
        else if (pick < 94)
            x.cmd = gmfd_pkg::CMD_ADD;
        else
            x.cmd = 3'($urandom_range(7, 5));
        return x;
    endfunction

    task automatic send_random(int n);
        repeat (n) send_word(random_word());
    endtask

    initial
    begin
        table_model.clear_table();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // plain gossip at reset settings
        send(gmfd_pkg::CMD_ADD, 2, 0, 0, 0);
        send(gmfd_pkg::CMD_ADD, 2, 0, 0, 0);
        send(gmfd_pkg::CMD_GOSSIP, 0, 32'hFFFF_FFFF, 16'hFFFF, 1);
        send(gmfd_pkg::CMD_GOSSIP, 5, 32'hFFFF_FFFF, 16'hFFFF, 1);
        send(gmfd_pkg::CMD_GOSSIP, 2, 7, 3, 0);
        send(gmfd_pkg::CMD_GOSSIP, 31, 0, 0, 0);
        send(gmfd_pkg::CMD_BEAT, 0, 0, 0, 0);
        send(3'd5, 1, 0, 0, 0);
        send(3'd6, 1, 0, 0, 0);
        send(3'd7, 1, 0, 0, 0);
        repeat (9) send(gmfd_pkg::CMD_CLOCK, 0, 0, 0, 0);
        send(gmfd_pkg::CMD_SWEEP, 0, 0, 0, 0);
        send(gmfd_pkg::CMD_GOSSIP, 5, 40, 1, 0);
        send(gmfd_pkg::CMD_ADD, 5, 0, 0, 0);
        send(gmfd_pkg::CMD_SWEEP, 0, 0, 0, 0);

        // suspicion mode, own entry at the top slot
        configure(31, 1, 255, 0);
        send(gmfd_pkg::CMD_GOSSIP, 31, 0, 0, 1);
        send(gmfd_pkg::CMD_GOSSIP, 31, 9, 5, 1);
        send(gmfd_pkg::CMD_GOSSIP, 3, 1, 2, 1);
        send(gmfd_pkg::CMD_GOSSIP, 3, 2, 3, 0);
        send(gmfd_pkg::CMD_GOSSIP, 3, 2, 9, 1);
        send(gmfd_pkg::CMD_CLOCK, 0, 0, 0, 0);
        send(gmfd_pkg::CMD_SWEEP, 0, 0, 0, 0);
        send_random(100);

        tx_idle_pct = 47;
        rx_idle_pct = 37;
        configure(0, 1, 3, 1);
        send_random(30);
        hold_req = 1;
        send_random(80);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        configure(17, 0, 0, 255);
        send_random(100);

        configure(9, 1, 8, 2);
        send_random(50);
        drain();
        send_random(50);

        drain();
        $display("Covered %0d input words and %0d result words over five register settings",
                 table_model.words_in, table_model.words_out);
        $display("Events seen: %0d suspected, %0d failed, %0d cleared, %0d refuted",
                 table_model.ev_seen[gmfd_pkg::EV_SUSPECTED],
                 table_model.ev_seen[gmfd_pkg::EV_FAILED],
                 table_model.ev_seen[gmfd_pkg::EV_CLEARED],
                 table_model.ev_seen[gmfd_pkg::EV_REFUTED]);
        if (table_model.errors == 0 && table_model.expected_events.size() == 0)
            $display("gossip_membership_failure_detector_top: match");
        else
            $display("gossip_membership_failure_detector_top: mismatch");
        $finish;
    end
endmodule

/* files.f */
+incdir+rtl/core
rtl/core/gmfd_pkg.sv
rtl/core/gmfd_ram.sv
rtl/core/gmfd_front.sv
rtl/core/gmfd_outq.sv
rtl/core/gmfd_back.sv
rtl/core/gossip_membership_failure_detector_top.sv
tb/tb_top.sv
